// ===== hdl/bhnf_pkg.sv =====
// Shared types and fixed widths for the Barnes-Hut node force kernel.
// No dependencies; imported by bhnf_sqrt_pipe, bhnf_front and the top level.
package bhnf_pkg;

  localparam int POS_W   = 32;   // Q16.16 position
  localparam int MASS_W  = 32;   // Q16.16 mass / size
  localparam int RATIO_W = 16;   // Q0.16 opening ratio
  localparam int CFG_W   = 32;   // widest config register
  localparam int CFG_IDX_W = 1;
  localparam int DIFF_W  = 33;   // signed position difference
  localparam int ABS_W   = 32;   // |difference| always fits 32 bits
  localparam int SQ_W    = 64;   // square of a difference
  localparam int PROD_W  = 96;   // G * mt * mn
  localparam int RAD_W   = 70;   // radicand width (even)
  localparam int ROOT_W  = 35;   // softened distance root
  localparam int FX_W    = 128;  // f * |d|
  localparam int FORCE_W = 48;
  localparam int MAG_W   = 47;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  typedef enum logic [1:0] {
    DEC_EMPTY = 2'd0,
    DEC_SELF  = 2'd1,
    DEC_FORCE = 2'd2,
    DEC_OPEN  = 2'd3
  } dec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAV_CONST = 1'b0,
    CFG_OPEN_RATIO = 1'b1
  } cfg_idx_t;

  // per-request control carried down the pipe
  typedef struct packed {
    dec_t dec;
    logic neg_x;
    logic neg_y;
  } flags_t;

  localparam int FLAGS_W = $bits(flags_t);

endpackage

// ===== hdl/bhnf_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on bhnf_pkg (widths); carries an opaque sideband word alongside.
module bhnf_sqrt_pipe import bhnf_pkg::*; #(
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int REM_W = ROOT_W + 2;

  logic              vld_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [SB_W-1:0]   sb_r   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic              src_vld;
    logic [REM_W-1:0]  src_rem;
    logic [ROOT_W-1:0] src_root;
    logic [RAD_W-1:0]  src_rad;
    logic [SB_W-1:0]   src_sb;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  test;
    logic              take;
    logic [REM_W+1:0]  diff;

    if (k == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_rad  = in_rad;
      assign src_sb   = in_sb;
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_rad  = rad_r[k-1];
      assign src_sb   = sb_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign trial = {src_rem, src_rad[RAD_W-1 -: 2]};
    assign test  = (REM_W+2)'({src_root, 2'b01});
    assign take  = trial >= test;
    assign diff  = trial - test;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
        root_r[k] <= {src_root[ROOT_W-2:0], take};
        rad_r[k]  <= {src_rad[RAD_W-3:0], 2'b00};
        sb_r[k]   <= src_sb;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_sb    = sb_r[ROOT_W-1];

endmodule

// ===== hdl/bhnf_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the remainder may be preloaded (must be below the divisor).
module bhnf_div_pipe #(
  parameter int NUM_W = 96,
  parameter int DEN_W = 50,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DEN_W-1:0] in_rem,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quo,
  output logic [SB_W-1:0]  out_sb
);

  logic             vld_r [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] num_r [NUM_W];  // dividend shifts out, quotient shifts in
  logic [DEN_W-1:0] den_r [NUM_W];
  logic [SB_W-1:0]  sb_r  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic             src_vld;
    logic [DEN_W-1:0] src_rem;
    logic [NUM_W-1:0] src_num;
    logic [DEN_W-1:0] src_den;
    logic [SB_W-1:0]  src_sb;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_rem = in_rem;
      assign src_num = in_num;
      assign src_den = in_den;
      assign src_sb  = in_sb;
    end else begin : g_next
      assign src_vld = vld_r[k-1];
      assign src_rem = rem_r[k-1];
      assign src_num = num_r[k-1];
      assign src_den = den_r[k-1];
      assign src_sb  = sb_r[k-1];
    end

    assign trial = {src_rem, src_num[NUM_W-1]};
    assign take  = trial >= {1'b0, src_den};
    assign diff  = trial - {1'b0, src_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_r[k] <= {src_num[NUM_W-2:0], take};
        den_r[k] <= src_den;
        sb_r[k]  <= src_sb;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_quo   = num_r[NUM_W-1];
  assign out_sb    = sb_r[NUM_W-1];

endmodule

// ===== hdl/bhnf_front.sv =====
// Front end: differences, squares, opening test, classification and G*mt*mn.
// Depends on bhnf_pkg; five register stages.
module bhnf_front import bhnf_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int D2E_W     = 66 - FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [POS_W-1:0]  in_target_x,
  input  logic signed [POS_W-1:0]  in_target_y,
  input  logic [MASS_W-1:0]        in_target_mass,
  input  logic signed [POS_W-1:0]  in_node_com_x,
  input  logic signed [POS_W-1:0]  in_node_com_y,
  input  logic [MASS_W-1:0]        in_node_mass,
  input  logic [MASS_W-1:0]        in_node_size,
  input  logic                     in_node_is_leaf,
  input  logic [MASS_W-1:0]        grav_const,
  input  logic [RATIO_W-1:0]       open_ratio,
  output logic                     out_valid,
  output flags_t                   out_flags,
  output logic [PROD_W-1:0]        out_prod,
  output logic [D2E_W-1:0]         out_d2e,
  output logic [ABS_W-1:0]         out_adx,
  output logic [ABS_W-1:0]         out_ady
);

  localparam logic [D2E_W-1:0] SOFT_EPS =
    D2E_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  // ---- stage 1: differences ----
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        adx_full, ady_full;
  logic                     v1_r, neg_x1_r, neg_y1_r, empty1_r, self1_r, leaf1_r;
  logic [ABS_W-1:0]         adx1_r, ady1_r;
  logic [MASS_W-1:0]        tm1_r, nm1_r, size1_r;

  assign dx = {in_node_com_x[POS_W-1], in_node_com_x} - {in_target_x[POS_W-1], in_target_x};
  assign dy = {in_node_com_y[POS_W-1], in_node_com_y} - {in_target_y[POS_W-1], in_target_y};
  assign adx_full = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ady_full = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_x1_r <= dx[DIFF_W-1];
      neg_y1_r <= dy[DIFF_W-1];
      empty1_r <= (in_node_mass == '0);
      self1_r  <= (dx == '0) && (dy == '0);
      leaf1_r  <= in_node_is_leaf;
      adx1_r   <= adx_full[ABS_W-1:0];
      ady1_r   <= ady_full[ABS_W-1:0];
      tm1_r    <= in_target_mass;
      nm1_r    <= in_node_mass;
      size1_r  <= in_node_size;
    end
  end

  // ---- stage 2: squares and products ----
  logic              v2_r, leaf2_r;
  flags_t            fl2_r;
  logic [SQ_W-1:0]   sx2_r, sy2_r, s2_2_r, gt2_r;
  logic [2*RATIO_W-1:0] th2_2_r;
  logic [ABS_W-1:0]  adx2_r, ady2_r;
  logic [MASS_W-1:0] nm2_r;
  dec_t              pre_dec;

  // preliminary code: only empty and self are final here
  always_comb begin
    if (empty1_r) begin
      pre_dec = DEC_EMPTY;
    end else if (self1_r) begin
      pre_dec = DEC_SELF;
    end else begin
      pre_dec = DEC_OPEN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx2_r   <= SQ_W'(adx1_r) * SQ_W'(adx1_r);
      sy2_r   <= SQ_W'(ady1_r) * SQ_W'(ady1_r);
      s2_2_r  <= SQ_W'(size1_r) * SQ_W'(size1_r);
      gt2_r   <= SQ_W'(grav_const) * SQ_W'(tm1_r);
      th2_2_r <= (2*RATIO_W)'(open_ratio) * (2*RATIO_W)'(open_ratio);
      fl2_r   <= '{dec: pre_dec, neg_x: neg_x1_r, neg_y: neg_y1_r};
      leaf2_r <= leaf1_r;
      adx2_r  <= adx1_r;
      ady2_r  <= ady1_r;
      nm2_r   <= nm1_r;
    end
  end

  // ---- stage 3: distance sum, softened d2, mass product halves ----
  logic              v3_r, leaf3_r;
  flags_t            fl3_r;
  logic [SQ_W:0]     sum3_r;
  logic [D2E_W-1:0]  d2e3_r;
  logic [SQ_W-1:0]   pl3_r, ph3_r, s2_3_r;
  logic [2*RATIO_W-1:0] th2_3_r;
  logic [ABS_W-1:0]  adx3_r, ady3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum3_r  <= (SQ_W+1)'(sx2_r) + (SQ_W+1)'(sy2_r);
      d2e3_r  <= D2E_W'(sx2_r >> FRAC_BITS) + D2E_W'(sy2_r >> FRAC_BITS) + SOFT_EPS;
      pl3_r   <= SQ_W'(gt2_r[31:0]) * SQ_W'(nm2_r);
      ph3_r   <= SQ_W'(gt2_r[63:32]) * SQ_W'(nm2_r);
      s2_3_r  <= s2_2_r;
      th2_3_r <= th2_2_r;
      fl3_r   <= fl2_r;
      leaf3_r <= leaf2_r;
      adx3_r  <= adx2_r;
      ady3_r  <= ady2_r;
    end
  end

  // ---- stage 4: theta^2 * d^2 halves, full mass product ----
  logic              v4_r, leaf4_r;
  flags_t            fl4_r;
  logic [64:0]       rl4_r;
  logic [63:0]       rh4_r;
  logic [PROD_W-1:0] p4_r;
  logic [SQ_W-1:0]   s2_4_r;
  logic [D2E_W-1:0]  d2e4_r;
  logic [ABS_W-1:0]  adx4_r, ady4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rl4_r   <= 65'(th2_3_r) * 65'(sum3_r[32:0]);
      rh4_r   <= 64'(th2_3_r) * 64'(sum3_r[64:33]);
      p4_r    <= (PROD_W'(ph3_r) << 32) + PROD_W'(pl3_r);
      s2_4_r  <= s2_3_r;
      d2e4_r  <= d2e3_r;
      fl4_r   <= fl3_r;
      leaf4_r <= leaf3_r;
      adx4_r  <= adx3_r;
      ady4_r  <= ady3_r;
    end
  end

  // ---- stage 5: opening test, final classification ----
  logic [96:0] rhs, lhs;
  logic        pass;
  flags_t      fl5_nxt;
  logic        v5_r;
  flags_t      fl5_r;
  logic [PROD_W-1:0] p5_r;
  logic [D2E_W-1:0]  d2e5_r;
  logic [ABS_W-1:0]  adx5_r, ady5_r;

  assign rhs  = (97'(rh4_r) << 33) + 97'(rl4_r);
  assign lhs  = {1'b0, s2_4_r, 32'b0};
  assign pass = leaf4_r || (lhs < rhs);

  always_comb begin
    fl5_nxt = fl4_r;
    if (fl4_r.dec == DEC_OPEN && pass) begin
      fl5_nxt.dec = DEC_FORCE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl5_r  <= fl5_nxt;
      p5_r   <= p4_r;
      d2e5_r <= d2e4_r;
      adx5_r <= adx4_r;
      ady5_r <= ady4_r;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_flags = fl5_r;
  assign out_prod  = p5_r;
  assign out_d2e   = d2e5_r;
  assign out_adx   = adx5_r;
  assign out_ady   = ady5_r;

endmodule

// ===== hdl/barnes_hut_node_force.sv =====
// Barnes-Hut node force kernel: one request per cycle while the output is not stalled.
// The pipe is built from the 35-stage square root, the 96-stage G*mt*mn/d2 divider
// and the 47-stage force dividers, plus 9 stages of multiply/compare/output.
// A stalled output freezes the whole pipe; in_stall follows it in the same cycle.
// rst_n (synchronous) clears all valid bits and loads grav_const = 1.0, theta = 0.5.
module barnes_hut_node_force import bhnf_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [POS_W-1:0]   in_target_x,
  input  logic signed [POS_W-1:0]   in_target_y,
  input  logic [MASS_W-1:0]         in_target_mass,
  input  logic signed [POS_W-1:0]   in_node_com_x,
  input  logic signed [POS_W-1:0]   in_node_com_y,
  input  logic [MASS_W-1:0]         in_node_mass,
  input  logic [MASS_W-1:0]         in_node_size,
  input  logic                      in_node_is_leaf,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_decision,
  output logic signed [FORCE_W-1:0] out_force_x,
  output logic signed [FORCE_W-1:0] out_force_y
);

  localparam int D2E_W  = 66 - FRAC_BITS;
  localparam int DN_W   = ROOT_W + FRAC_BITS;
  localparam int HI_W   = FX_W - MAG_W;
  localparam int SQ_SB_W = FLAGS_W + PROD_W + D2E_W + 2*ABS_W;
  localparam int DV_SB_W = FLAGS_W + ROOT_W + 2*ABS_W;

  logic en;

  // ---- configuration registers ----
  logic [MASS_W-1:0]  grav_const_r;
  logic [RATIO_W-1:0] open_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_const_r <= MASS_W'(65536);
      open_ratio_r <= RATIO_W'(32768);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRAV_CONST: grav_const_r <= cfg_data[MASS_W-1:0];
        CFG_OPEN_RATIO: open_ratio_r <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // global pipe advance
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---- front end ----
  logic              fe_valid;
  flags_t            fe_flags;
  logic [PROD_W-1:0] fe_prod;
  logic [D2E_W-1:0]  fe_d2e;
  logic [ABS_W-1:0]  fe_adx, fe_ady;

  bhnf_front #(.FRAC_BITS(FRAC_BITS), .D2E_W(D2E_W)) u_front (
    .clk, .rst_n, .en,
    .in_valid, .in_target_x, .in_target_y, .in_target_mass,
    .in_node_com_x, .in_node_com_y, .in_node_mass, .in_node_size, .in_node_is_leaf,
    .grav_const(grav_const_r), .open_ratio(open_ratio_r),
    .out_valid(fe_valid), .out_flags(fe_flags), .out_prod(fe_prod),
    .out_d2e(fe_d2e), .out_adx(fe_adx), .out_ady(fe_ady)
  );

  // ---- softened distance r = sqrt(d2e << F) ----
  logic [RAD_W-1:0]   sq_rad;
  logic [SQ_SB_W-1:0] sq_sb_in, sq_sb_out;
  logic               sq_valid;
  logic [ROOT_W-1:0]  sq_root;
  flags_t             sq_flags;
  logic [PROD_W-1:0]  sq_prod;
  logic [D2E_W-1:0]   sq_d2e;
  logic [ABS_W-1:0]   sq_adx, sq_ady;

  assign sq_rad   = RAD_W'({fe_d2e, FRAC_BITS'(0)});
  assign sq_sb_in = {fe_flags, fe_prod, fe_d2e, fe_adx, fe_ady};

  bhnf_sqrt_pipe #(.SB_W(SQ_SB_W)) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid(fe_valid), .in_rad(sq_rad), .in_sb(sq_sb_in),
    .out_valid(sq_valid), .out_root(sq_root), .out_sb(sq_sb_out)
  );

  assign {sq_flags, sq_prod, sq_d2e, sq_adx, sq_ady} = sq_sb_out;

  // ---- f = G*mt*mn / d2e ----
  logic [DV_SB_W-1:0] fd_sb_in, fd_sb_out;
  logic               fd_valid;
  logic [PROD_W-1:0]  fd_quo;
  flags_t             fd_flags;
  logic [ROOT_W-1:0]  fd_root;
  logic [ABS_W-1:0]   fd_adx, fd_ady;

  assign fd_sb_in = {sq_flags, sq_root, sq_adx, sq_ady};

  bhnf_div_pipe #(.NUM_W(PROD_W), .DEN_W(D2E_W), .SB_W(DV_SB_W)) u_fdiv (
    .clk, .rst_n, .en,
    .in_valid(sq_valid), .in_rem(D2E_W'(0)), .in_num(sq_prod), .in_den(sq_d2e),
    .in_sb(fd_sb_in),
    .out_valid(fd_valid), .out_quo(fd_quo), .out_sb(fd_sb_out)
  );

  assign {fd_flags, fd_root, fd_adx, fd_ady} = fd_sb_out;

  // ---- m1: f * |d| partial products ----
  logic        m1_v_r;
  flags_t      m1_fl_r;
  logic [DN_W-1:0] m1_dn_r;
  logic [63:0] px0_r, px1_r, px2_r, py0_r, py1_r, py2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px0_r   <= 64'(fd_quo[31:0])  * 64'(fd_adx);
      px1_r   <= 64'(fd_quo[63:32]) * 64'(fd_adx);
      px2_r   <= 64'(fd_quo[95:64]) * 64'(fd_adx);
      py0_r   <= 64'(fd_quo[31:0])  * 64'(fd_ady);
      py1_r   <= 64'(fd_quo[63:32]) * 64'(fd_ady);
      py2_r   <= 64'(fd_quo[95:64]) * 64'(fd_ady);
      m1_dn_r <= {fd_root, FRAC_BITS'(0)};
      m1_fl_r <= fd_flags;
    end
  end

  // ---- m2: sum partial products ----
  logic            m2_v_r;
  flags_t          m2_fl_r;
  logic [DN_W-1:0] m2_dn_r;
  logic [FX_W-1:0] nx2_r, ny2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx2_r   <= FX_W'(px0_r) + (FX_W'(px1_r) << 32) + (FX_W'(px2_r) << 64);
      ny2_r   <= FX_W'(py0_r) + (FX_W'(py1_r) << 32) + (FX_W'(py2_r) << 64);
      m2_dn_r <= m1_dn_r;
      m2_fl_r <= m1_fl_r;
    end
  end

  // ---- m3: saturation check, preload remainder with the high part ----
  logic [HI_W-1:0] hx, hy;
  logic            ovfx, ovfy;
  logic            m3_v_r, m3_ovfx_r, m3_ovfy_r;
  flags_t          m3_fl_r;
  logic [DN_W-1:0] m3_dn_r, m3_remx_r, m3_remy_r;
  logic [MAG_W-1:0] m3_lowx_r, m3_lowy_r;

  assign hx   = nx2_r[FX_W-1:MAG_W];
  assign hy   = ny2_r[FX_W-1:MAG_W];
  assign ovfx = hx >= HI_W'(m2_dn_r);
  assign ovfy = hy >= HI_W'(m2_dn_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m3_ovfx_r <= ovfx;
      m3_ovfy_r <= ovfy;
      m3_remx_r <= ovfx ? DN_W'(0) : hx[DN_W-1:0];
      m3_remy_r <= ovfy ? DN_W'(0) : hy[DN_W-1:0];
      m3_lowx_r <= nx2_r[MAG_W-1:0];
      m3_lowy_r <= ny2_r[MAG_W-1:0];
      m3_dn_r   <= m2_dn_r;
      m3_fl_r   <= m2_fl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= fd_valid;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
    end
  end

  // ---- force magnitudes: (f*|d|) / (r << F) ----
  logic               dvx_valid, dvy_valid;
  logic [MAG_W-1:0]   dvx_quo, dvy_quo;
  logic [FLAGS_W:0]   dvx_sb;
  logic               dvy_sb;
  flags_t             dv_flags;
  logic               dv_ovfx;

  bhnf_div_pipe #(.NUM_W(MAG_W), .DEN_W(DN_W), .SB_W(FLAGS_W + 1)) u_xdiv (
    .clk, .rst_n, .en,
    .in_valid(m3_v_r), .in_rem(m3_remx_r), .in_num(m3_lowx_r), .in_den(m3_dn_r),
    .in_sb({m3_fl_r, m3_ovfx_r}),
    .out_valid(dvx_valid), .out_quo(dvx_quo), .out_sb(dvx_sb)
  );

  bhnf_div_pipe #(.NUM_W(MAG_W), .DEN_W(DN_W), .SB_W(1)) u_ydiv (
    .clk, .rst_n, .en,
    .in_valid(m3_v_r), .in_rem(m3_remy_r), .in_num(m3_lowy_r), .in_den(m3_dn_r),
    .in_sb(m3_ovfy_r),
    .out_valid(dvy_valid), .out_quo(dvy_quo), .out_sb(dvy_sb)
  );

  assign {dv_flags, dv_ovfx} = dvx_sb;

  // ---- output register: saturate, sign, mask ----
  logic [MAG_W-1:0]   mag_x, mag_y;
  logic [FORCE_W-1:0] fx_nxt, fy_nxt;
  logic               out_valid_r;
  dec_t               out_dec_r;
  logic [FORCE_W-1:0] out_fx_r, out_fy_r;

  assign mag_x = dv_ovfx ? MAG_MAX : dvx_quo;
  assign mag_y = dvy_sb  ? MAG_MAX : dvy_quo;

  always_comb begin
    fx_nxt = '0;
    fy_nxt = '0;
    if (dv_flags.dec == DEC_FORCE) begin
      fx_nxt = dv_flags.neg_x ? (FORCE_W'(0) - FORCE_W'(mag_x)) : FORCE_W'(mag_x);
      fy_nxt = dv_flags.neg_y ? (FORCE_W'(0) - FORCE_W'(mag_y)) : FORCE_W'(mag_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dvx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dec_r <= dv_flags.dec;
      out_fx_r  <= fx_nxt;
      out_fy_r  <= fy_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_decision = out_dec_r;
  assign out_force_x  = out_fx_r;
  assign out_force_y  = out_fy_r;

`ifndef SYNTHESIS
  // the two force dividers run in lock step
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dvx_valid == dvy_valid)
    else $error("force dividers out of step");

  // only an applied force carries a nonzero value
  a_zero_unless_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_decision != DEC_FORCE) |-> (out_force_x == '0) && (out_force_y == '0))
    else $error("nonzero force on a skipped or opened node");

  // saturation is symmetric, the most negative code never appears
  a_sat_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_force_x != {1'b1, {MAG_W{1'b0}}}) &&
                  (out_force_y != {1'b1, {MAG_W{1'b0}}}))
    else $error("force reached the most negative code");
`endif

endmodule
